// File: rtl/sync_header_sum_checksum_deframer_defines.svh
// assertion macros for the sync header deframer checker
// no dependencies; pulled in by the checker file only
`ifndef SYNC_HEADER_SUM_CHECKSUM_DEFRAMER_DEFINES_SVH
`define SYNC_HEADER_SUM_CHECKSUM_DEFRAMER_DEFINES_SVH

// antecedent holds, consequent holds in the same cycle
`define SHSD_ASSERT_SAME(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// antecedent holds, consequent holds in the cycle after, no reset gating
`define SHSD_ASSERT_NEXT(label, clk, ante, cons, msg) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/shsd_pkg.sv
// shared types and constants for the sync header deframer
// no dependencies
package shsd_pkg;

    localparam int BYTE_W       = 8;
    localparam int HDR_LEN_W    = 3;
    localparam int CFG_INDEX_W  = 2;
    localparam int QUEUE_DEPTH  = 2;
    localparam int QUEUE_PTR_W  = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W  = $clog2(QUEUE_DEPTH + 1);

    localparam logic [BYTE_W-1:0]    SYNC_VALUE_RST     = 8'hAA;
    localparam logic [HDR_LEN_W-1:0] HEADER_LENGTH_RST  = 3'd4;
    localparam logic [BYTE_W-1:0]    PAYLOAD_LENGTH_RST = 8'd190;
    localparam logic [BYTE_W-1:0]    POS_MAX            = 8'hFF;

    localparam logic [CFG_INDEX_W-1:0] CFG_SYNC_VALUE     = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_HEADER_LENGTH  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_PAYLOAD_LENGTH = 2'd2;

    typedef struct packed {
        logic [BYTE_W-1:0] frame_byte;
        logic [BYTE_W-1:0] frame_position;
        logic              frame_last;
        logic              checksum_good;
    } result_t;

    typedef struct packed {
        logic [BYTE_W-1:0]    sync_value;
        logic [HDR_LEN_W-1:0] header_length;
        logic [BYTE_W-1:0]    payload_length;
    } cfg_t;

endpackage

// File: rtl/sync_header_sum_checksum_deframer.sv
// top level of the sync header deframer with 8-bit additive checksum
// depends on shsd_pkg, shsd_front, shsd_queue, shsd_back
//
// channel   direction  ports
// cfg       in         cfg_valid cfg_ready cfg_index cfg_data
// s         in         s_valid s_ready s_rx_byte
// m         out        m_valid m_ready m_frame_byte m_frame_position m_frame_last
//                      m_checksum_good
//
// one input transaction per cycle unless m stalls; the front updates count and sum per byte
// a result reaches m through the queue write and then the output register
// s_ready drops only when the two-entry queue is full, i.e. while m is stalled
// synchronous active-low reset clears count, sum, queue and output valid; registers reload defaults
// cfg_ready is always high; a write takes effect on the next cycle
module sync_header_sum_checksum_deframer (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [shsd_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [shsd_pkg::BYTE_W-1:0]          cfg_data,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic [shsd_pkg::BYTE_W-1:0]          s_rx_byte,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic [shsd_pkg::BYTE_W-1:0]          m_frame_byte,
    output logic [shsd_pkg::BYTE_W-1:0]          m_frame_position,
    output logic                                 m_frame_last,
    output logic                                 m_checksum_good
);
    import shsd_pkg::*;

    logic    push_valid, push_ready;
    result_t push_data;
    logic    pop_valid, pop_ready;
    result_t pop_data;

    shsd_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_rx_byte  (s_rx_byte),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    shsd_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    shsd_back u_back (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .pop_valid        (pop_valid),
        .pop_ready        (pop_ready),
        .pop_data         (pop_data),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_frame_byte     (m_frame_byte),
        .m_frame_position (m_frame_position),
        .m_frame_last     (m_frame_last),
        .m_checksum_good  (m_checksum_good)
    );

endmodule

// File: rtl/shsd_queue.sv
// two-entry result queue between the front and back parts
// depends on shsd_pkg
module shsd_queue (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push_valid,
    output logic              push_ready,
    input  shsd_pkg::result_t push_data,
    output logic              pop_valid,
    input  logic              pop_ready,
    output shsd_pkg::result_t pop_data
);
    import shsd_pkg::*;

    result_t                mem_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_CNT_W-1:0] count_reg, count_next;
    logic                   do_push, do_pop;

    assign push_ready = (count_reg != QUEUE_CNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                        : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                        : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// File: rtl/shsd_front.sv
// front part: configuration registers, sync hunt, position count and payload sum
// depends on shsd_pkg
module shsd_front (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [shsd_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [shsd_pkg::BYTE_W-1:0]          cfg_data,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic [shsd_pkg::BYTE_W-1:0]          s_rx_byte,
    output logic                                 push_valid,
    input  logic                                 push_ready,
    output shsd_pkg::result_t                    push_data
);
    import shsd_pkg::*;

    cfg_t              cfg_reg, cfg_next;
    logic [BYTE_W-1:0] pos_reg, pos_next;
    logic [BYTE_W-1:0] sum_reg, sum_next;
    logic [BYTE_W:0]   end_sum;
    logic [BYTE_W-1:0] end_pos;
    logic              accept;
    logic              hunting;

    assign cfg_ready = 1'b1;
    assign s_ready   = push_ready;
    assign accept    = s_valid && s_ready;
    assign end_sum   = {1'b0, {(BYTE_W - HDR_LEN_W){1'b0}}, cfg_reg.header_length}
                     + {1'b0, cfg_reg.payload_length};
    assign end_pos   = end_sum[BYTE_W] ? POS_MAX : end_sum[BYTE_W-1:0];
    assign hunting   = pos_reg < {{(BYTE_W - HDR_LEN_W){1'b0}}, cfg_reg.header_length};

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_SYNC_VALUE:     cfg_next.sync_value     = cfg_data;
                CFG_HEADER_LENGTH:  cfg_next.header_length  = cfg_data[HDR_LEN_W-1:0];
                CFG_PAYLOAD_LENGTH: cfg_next.payload_length = cfg_data;
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb begin
        pos_next                 = pos_reg;
        sum_next                 = sum_reg;
        push_valid               = 1'b0;
        push_data.frame_byte     = s_rx_byte;
        push_data.frame_position = pos_reg;
        push_data.frame_last     = 1'b0;
        push_data.checksum_good  = 1'b0;
        if (accept) begin
            if (hunting) begin
                if (s_rx_byte == cfg_reg.sync_value) begin
                    push_valid = 1'b1;
                    pos_next   = pos_reg + 1'b1;
                end else begin
                    pos_next = '0;
                    sum_next = '0;
                end
            end else if (pos_reg < end_pos) begin
                push_valid = 1'b1;
                pos_next   = pos_reg + 1'b1;
                sum_next   = sum_reg + s_rx_byte;
            end else if (pos_reg == end_pos) begin
                push_valid              = 1'b1;
                push_data.frame_last    = 1'b1;
                push_data.checksum_good = (s_rx_byte == sum_reg);
                pos_next                = '0;
                sum_next                = '0;
            end else begin
                pos_next = '0;
                sum_next = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.sync_value     <= SYNC_VALUE_RST;
            cfg_reg.header_length  <= HEADER_LENGTH_RST;
            cfg_reg.payload_length <= PAYLOAD_LENGTH_RST;
            pos_reg                <= '0;
            sum_reg                <= '0;
        end else begin
            cfg_reg <= cfg_next;
            pos_reg <= pos_next;
            sum_reg <= sum_next;
        end
    end

endmodule

// File: rtl/shsd_back.sv
// back part: output register that drains the queue onto the result channel
// depends on shsd_pkg
module shsd_back (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        pop_valid,
    output logic                        pop_ready,
    input  shsd_pkg::result_t           pop_data,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [shsd_pkg::BYTE_W-1:0] m_frame_byte,
    output logic [shsd_pkg::BYTE_W-1:0] m_frame_position,
    output logic                        m_frame_last,
    output logic                        m_checksum_good
);
    import shsd_pkg::*;

    logic    out_valid_reg, out_valid_next;
    result_t out_data_reg;

    assign pop_ready      = !out_valid_reg || m_ready;
    assign out_valid_next = pop_ready ? pop_valid : out_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop_valid && pop_ready) begin
            out_data_reg <= pop_data;
        end
    end

    assign m_valid          = out_valid_reg;
    assign m_frame_byte     = out_data_reg.frame_byte;
    assign m_frame_position = out_data_reg.frame_position;
    assign m_frame_last     = out_data_reg.frame_last;
    assign m_checksum_good  = out_data_reg.checksum_good;

endmodule

// File: rtl/shsd_checker.sv
// port-level checker for the sync header deframer, bound to the top level
// depends on sync_header_sum_checksum_deframer_defines.svh and shsd_pkg
`include "sync_header_sum_checksum_deframer_defines.svh"

module shsd_checker (
    input logic                        aclk,
    input logic                        aresetn,
    input logic                        s_ready,
    input logic                        m_valid,
    input logic                        m_ready,
    input logic [shsd_pkg::BYTE_W-1:0] m_frame_byte,
    input logic [shsd_pkg::BYTE_W-1:0] m_frame_position,
    input logic                        m_frame_last,
    input logic                        m_checksum_good
);
    import shsd_pkg::*;

    `SHSD_ASSERT_SAME(a_m_hold, aclk, aresetn, m_valid && !m_ready && $past(m_valid && !m_ready), m_valid && $stable(m_frame_byte) && $stable(m_frame_position) && $stable(m_frame_last) && $stable(m_checksum_good), "stalled result transaction changed")
    `SHSD_ASSERT_SAME(a_good_only_last, aclk, aresetn, m_valid && !m_frame_last, !m_checksum_good, "checksum flag set on a byte that is not last")
    `SHSD_ASSERT_NEXT(a_reset_empty, aclk, !aresetn, !m_valid && s_ready, "result pending or input blocked after reset")
    `SHSD_ASSERT_SAME(a_idle_ready, aclk, aresetn, !m_valid && $past(!m_valid) && $past(aresetn), s_ready, "input blocked while output side is empty")

endmodule

bind sync_header_sum_checksum_deframer shsd_checker u_shsd_checker (.*);

// File: tb/sv/sync_header_sum_checksum_deframer_tb.sv
// self-checking testbench for the sync header deframer with 8-bit additive checksum
// depends on shsd_pkg and sync_header_sum_checksum_deframer; predicts every result in-line
`timescale 1ns / 100ps

module sync_header_sum_checksum_deframer_tb;
    import shsd_pkg::*;

    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 6;
    localparam int HOLD_CYCLES  = 300;
    localparam int MAX_PRINTS   = 60;
    localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED = 2'd3;

    logic                   aclk;
    logic                   aresetn   = 1'b0;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [BYTE_W-1:0]      cfg_data  = '0;
    logic                   s_valid   = 1'b0;
    logic                   s_ready;
    logic [BYTE_W-1:0]      s_rx_byte = '0;
    logic                   m_valid;
    logic                   m_ready   = 1'b0;
    logic [BYTE_W-1:0]      m_frame_byte;
    logic [BYTE_W-1:0]      m_frame_position;
    logic                   m_frame_last;
    logic                   m_checksum_good;

    // predicted block state and registers
    logic [BYTE_W-1:0]    sync_q;
    logic [HDR_LEN_W-1:0] hdr_len_q;
    logic [BYTE_W-1:0]    pay_len_q;
    logic [BYTE_W-1:0]    frame_pos_q;
    logic [BYTE_W-1:0]    payload_sum_q;

    result_t pending_frame_bytes[$];
    int      mismatch_count = 0;
    int      emitted_count  = 0;
    int      idle_pct_send  = 0;
    int      stall_pct_recv = 0;
    int      hold_left      = 0;
    int      quiet_cycles   = 0;

    sync_header_sum_checksum_deframer DUT (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_rx_byte        (s_rx_byte),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_frame_byte     (m_frame_byte),
        .m_frame_position (m_frame_position),
        .m_frame_last     (m_frame_last),
        .m_checksum_good  (m_checksum_good)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    function automatic bit deframe_byte(input logic [BYTE_W-1:0] b, output result_t r);
        int pos;
        int csum_pos;
        pos      = frame_pos_q;
        csum_pos = int'(hdr_len_q) + int'(pay_len_q);
        if (csum_pos > int'(POS_MAX))
            csum_pos = int'(POS_MAX);
        r = '0;
        if (pos < int'(hdr_len_q)) begin
            if (b == sync_q) begin
                r.frame_byte     = b;
                r.frame_position = pos[7:0];
                frame_pos_q      = pos[7:0] + 8'd1;
                return 1'b1;
            end
            frame_pos_q   = '0;
            payload_sum_q = '0;
            return 1'b0;
        end
        if (pos < csum_pos) begin
            r.frame_byte     = b;
            r.frame_position = pos[7:0];
            payload_sum_q    = payload_sum_q + b;
            frame_pos_q      = pos[7:0] + 8'd1;
            return 1'b1;
        end
        if (pos == csum_pos) begin
            r.frame_byte     = b;
            r.frame_position = pos[7:0];
            r.frame_last     = 1'b1;
            r.checksum_good  = (b == payload_sum_q);
            frame_pos_q      = '0;
            payload_sum_q    = '0;
            return 1'b1;
        end
        frame_pos_q   = '0;
        payload_sum_q = '0;
        return 1'b0;
    endfunction

    function automatic logic [BYTE_W-1:0] pick_data_byte();
        case ($urandom_range(0, 9))
            0: return 8'h00;
            1: return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    task automatic report_mismatch(input string what, input logic [BYTE_W-1:0] want,
                                   input logic [BYTE_W-1:0] got);
        mismatch_count++;
        if (mismatch_count <= MAX_PRINTS)
            $display("mismatch on %s: expected %0h got %0h at %0t", what, want, got, $time);
    endtask

    // all stimulus tasks start and end at a falling edge
    task automatic send_byte(input logic [BYTE_W-1:0] b);
        result_t r;
        while ($urandom_range(0, 99) < idle_pct_send) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid   <= 1'b1;
        s_rx_byte <= b;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        if (deframe_byte(b, r)) begin
            pending_frame_bytes.push_back(r);
            emitted_count++;
        end
        @(negedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [BYTE_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge aclk);
        while (!cfg_ready)
            @(posedge aclk);
        case (idx)
            CFG_SYNC_VALUE:     sync_q    = data;
            CFG_HEADER_LENGTH:  hdr_len_q = data[HDR_LEN_W-1:0];
            CFG_PAYLOAD_LENGTH: pay_len_q = data;
            default: ;
        endcase
        @(negedge aclk);
        cfg_valid <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic settle();
        s_valid <= 1'b0;
        while (pending_frame_bytes.size() != 0)
            @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    task automatic send_frame(input int keep, input bit bad_sum);
        logic [BYTE_W-1:0] seq[$];
        logic [BYTE_W-1:0] sum;
        logic [BYTE_W-1:0] b;
        int                csum_pos;
        int                n_pay;
        csum_pos = int'(hdr_len_q) + int'(pay_len_q);
        if (csum_pos > 255)
            csum_pos = 255;
        n_pay = csum_pos - int'(hdr_len_q);
        sum   = '0;
        repeat (hdr_len_q) seq.push_back(sync_q);
        repeat (n_pay) begin
            b   = pick_data_byte();
            sum = sum + b;
            seq.push_back(b);
        end
        seq.push_back(bad_sum ? sum ^ 8'($urandom_range(1, 255)) : sum);
        foreach (seq[i])
            if (keep < 0 || i < keep)
                send_byte(seq[i]);
    endtask

    task automatic send_noise();
        int k;
        if ($urandom_range(0, 1)) begin
            // header cut short by a wrong byte
            k = (hdr_len_q > 0) ? $urandom_range(0, int'(hdr_len_q) - 1) : 0;
            repeat (k) send_byte(sync_q);
            send_byte(sync_q ^ 8'($urandom_range(1, 255)));
        end else begin
            repeat ($urandom_range(1, 4)) send_byte(pick_data_byte());
        end
    endtask

    task automatic pick_config(input bit extreme);
        logic [BYTE_W-1:0] v;
        if ($urandom_range(0, 3) != 0) begin
            case ($urandom_range(0, 3))
                0: v = 8'h00;
                1: v = 8'hFF;
                default: v = 8'($urandom);
            endcase
            write_reg(CFG_SYNC_VALUE, v);
        end
        if (extreme || $urandom_range(0, 4) != 0) begin
            v[7:3] = 5'($urandom);
            if (extreme)
                v[2:0] = $urandom_range(0, 1) ? 3'd7 : 3'd0;
            else
                v[2:0] = 3'($urandom_range(0, 7));
            write_reg(CFG_HEADER_LENGTH, v);
        end
        if (extreme || $urandom_range(0, 4) != 0) begin
            if (extreme)
                case ($urandom_range(0, 2))
                    0: v = 8'd0;
                    1: v = 8'd250;
                    default: v = 8'd255;
                endcase
            else
                v = 8'($urandom_range(0, 6));
            write_reg(CFG_PAYLOAD_LENGTH, v);
        end
        if ($urandom_range(0, 7) == 0)
            write_reg(CFG_UNUSED, 8'($urandom));
    endtask

    task automatic run_traffic(input int n_results, input int send_pct, input int recv_pct,
                               input bit extreme);
        int start;
        int since_cfg;
        settle();
        idle_pct_send  = send_pct;
        stall_pct_recv = recv_pct;
        pick_config(extreme);
        start     = emitted_count;
        since_cfg = emitted_count;
        while (emitted_count - start < n_results) begin
            case ($urandom_range(0, 9))
                0, 1: send_noise();
                2: send_frame($urandom_range(0, 8), 1'b0);
                default: send_frame(-1, $urandom_range(0, 3) == 0);
            endcase
            if (emitted_count - since_cfg >= 60) begin
                settle();
                pick_config(extreme);
                since_cfg = emitted_count;
            end
        end
    endtask

    task automatic test_directed_cases();
        idle_pct_send  = 0;
        stall_pct_recv = 0;
        // reset registers: restarted hunt, then header and part of a payload
        send_byte(8'h00);
        send_byte(8'hAA);
        send_byte(8'hAA);
        send_byte(8'h55);
        repeat (4) send_byte(8'hAA);
        send_byte(8'hFF);
        send_byte(8'h01);
        settle();
        // frame shortened under a half-received frame, then zero payload
        write_reg(CFG_HEADER_LENGTH, 8'hF9);
        write_reg(CFG_PAYLOAD_LENGTH, 8'd0);
        write_reg(CFG_UNUSED, 8'h5A);
        send_byte(8'h12);
        send_byte(8'hAA);
        send_byte(8'h00);
        send_byte(8'hAA);
        send_byte(8'h01);
        settle();
        // zero header: every byte opens a frame directly
        write_reg(CFG_SYNC_VALUE, 8'h00);
        write_reg(CFG_HEADER_LENGTH, 8'h00);
        send_byte(8'h00);
        send_byte(8'h7F);
        settle();
        write_reg(CFG_PAYLOAD_LENGTH, 8'd2);
        send_byte(8'h80);
        send_byte(8'h80);
        send_byte(8'h00);
    endtask

    task automatic test_default_frames();
        settle();
        idle_pct_send  = 0;
        stall_pct_recv = 0;
        write_reg(CFG_SYNC_VALUE, SYNC_VALUE_RST);
        write_reg(CFG_HEADER_LENGTH, {5'd0, HEADER_LENGTH_RST});
        write_reg(CFG_PAYLOAD_LENGTH, PAYLOAD_LENGTH_RST);
        send_frame(-1, 1'b0);
        send_noise();
        send_frame(-1, 1'b1);
    endtask

    task automatic test_sender_gaps();
        run_traffic(280, 52, 0, 1'b0);
    endtask

    task automatic test_receiver_stalls();
        run_traffic(280, 0, 52, 1'b0);
    endtask

    task automatic test_both_idle();
        run_traffic(280, 25, 25, 1'b0);
    endtask

    task automatic test_backpressure();
        settle();
        idle_pct_send  = 0;
        stall_pct_recv = 0;
        write_reg(CFG_HEADER_LENGTH, 8'd2);
        write_reg(CFG_PAYLOAD_LENGTH, 8'd5);
        hold_left = HOLD_CYCLES;
        repeat (12) send_frame(-1, $urandom_range(0, 3) == 0);
    endtask

    task automatic test_extremes();
        run_traffic(280, 25, 25, 1'b1);
    endtask

    // receiver side
    always @(negedge aclk) begin
        if (hold_left > 0) begin
            m_ready <= 1'b0;
            hold_left--;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= stall_pct_recv);
        end
    end

    always @(posedge aclk) begin : check_result
        result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_frame_bytes.size() == 0) begin
                report_mismatch("unexpected transaction", 8'h00, m_frame_byte);
            end else begin
                want = pending_frame_bytes.pop_front();
                if (m_frame_byte !== want.frame_byte)
                    report_mismatch("frame_byte", want.frame_byte, m_frame_byte);
                if (m_frame_position !== want.frame_position)
                    report_mismatch("frame_position", want.frame_position, m_frame_position);
                if (m_frame_last !== want.frame_last)
                    report_mismatch("frame_last", {7'd0, want.frame_last}, {7'd0, m_frame_last});
                if (m_checksum_good !== want.checksum_good)
                    report_mismatch("checksum_good", {7'd0, want.checksum_good},
                                    {7'd0, m_checksum_good});
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
            $display("FAIL sync_header_sum_checksum_deframer");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        sync_q        = SYNC_VALUE_RST;
        hdr_len_q     = HEADER_LENGTH_RST;
        pay_len_q     = PAYLOAD_LENGTH_RST;
        frame_pos_q   = '0;
        payload_sum_q = '0;
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_directed_cases();
        test_default_frames();
        test_sender_gaps();
        test_receiver_stalls();
        test_both_idle();
        test_backpressure();
        test_extremes();

        s_valid <= 1'b0;
        while (pending_frame_bytes.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_count == 0 && pending_frame_bytes.size() == 0)
            $display("PASS sync_header_sum_checksum_deframer");
        else
            $display("FAIL sync_header_sum_checksum_deframer");
        $finish;
    end

endmodule
